// ===== sv/apff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_pkg
// Shared types, widths, register codes and helpers of the anisotropic
// phase-field edge flux block.
// ----------------------------------------------------------------------------
package apff_pkg;

  localparam int PHI_W   = 16;   // phi, signed Q2.14
  localparam int GRAD_W  = 27;   // edge gradient components, signed Q.14
  localparam int FLUX_W  = 32;   // flux, signed Q8.24
  localparam int CFG_W   = 32;   // widest configuration register
  localparam int COEF_W  = 18;   // Q2.16 coefficients
  localparam int INV_W   = 24;   // Q8.16 reciprocal spacing
  localparam int DIV_W   = 62;   // divider numerator and denominator
  localparam int QUO_W   = 17;   // divider quotient, Q1.16
  localparam int PIPE_LAT = 32;  // register stages from input to last flux stage

  typedef enum logic [2:0] {
    CFG_BASE_COEF   = 3'd0,
    CFG_ANISO       = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INV_SPACING = 3'd3,
    CFG_FLAT_THRESH = 3'd4
  } cfg_idx_t;

  localparam logic [COEF_W-1:0] BASE_COEF_RST   = 18'd53739;
  localparam logic [COEF_W-1:0] ANISO_RST       = 18'd15729;
  localparam logic [COEF_W-1:0] DERIV_GAIN_RST  = 18'd51590;
  localparam logic [INV_W-1:0]  INV_SPACING_RST = 24'd65536;
  localparam logic [31:0]       FLAT_THRESH_RST = 32'd1;

  typedef struct packed {
    logic signed [PHI_W-1:0] north_west;
    logic signed [PHI_W-1:0] north;
    logic signed [PHI_W-1:0] north_east;
    logic signed [PHI_W-1:0] west;
    logic signed [PHI_W-1:0] phi_center;
    logic signed [PHI_W-1:0] east;
    logic signed [PHI_W-1:0] south_west;
    logic signed [PHI_W-1:0] south;
    logic signed [PHI_W-1:0] south_east;
  } stencil_t;

  typedef struct packed {
    logic signed [FLUX_W-1:0] flux_right;
    logic signed [FLUX_W-1:0] flux_left;
    logic signed [FLUX_W-1:0] flux_top;
    logic signed [FLUX_W-1:0] flux_bottom;
    logic                     saturated;
  } flux_t;

  // Least right shift that brings a 27-bit magnitude below 2^15.
  function automatic logic [3:0] norm_shift(input logic [GRAD_W-1:0] mx);
    logic [3:0] k;
    k = 4'd0;
    for (int j = 1; j <= GRAD_W - 15; j++) begin
      if (mx[14+j]) begin
        k = 4'(j);
      end
    end
    return k;
  endfunction

endpackage

// ===== sv/apff_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_if
// Valid/ready request channels for neighborhoods in and fluxes out.
// ----------------------------------------------------------------------------
interface apff_in_if;
  import apff_pkg::*;
  logic     valid;
  logic     ready;
  stencil_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apff_out_if;
  import apff_pkg::*;
  logic  valid;
  logic  ready;
  flux_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/apff_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_stencil
// Two stages: corner-sum differences, then scaling of the tangential
// differences by inv_spacing. Emits normal and tangential edge gradients.
// ----------------------------------------------------------------------------
module apff_stencil
  import apff_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  stencil_t                 nb,
  input  logic [INV_W-1:0]         inv_spacing,
  output logic signed [GRAD_W-1:0] right_n,
  output logic signed [GRAD_W-1:0] right_t,
  output logic signed [GRAD_W-1:0] left_n,
  output logic signed [GRAD_W-1:0] left_t,
  output logic signed [GRAD_W-1:0] top_n,
  output logic signed [GRAD_W-1:0] top_t,
  output logic signed [GRAD_W-1:0] bottom_n,
  output logic signed [GRAD_W-1:0] bottom_t
);

  logic signed [18:0] pp, pm, mp, mm;
  logic signed [18:0] dr_r, dl_r, dt_r, db_r;
  logic signed [16:0] nr_r, nl_r, nt_r, nb_r;
  logic signed [43:0] pr_r, pl_r, pt_r, pb_r;
  logic signed [GRAD_W-1:0] nr2_r, nl2_r, nt2_r, nb2_r;
  logic signed [24:0] inv_s;

  assign pp = 19'(nb.north_east) + 19'(nb.north) + 19'(nb.east) + 19'(nb.phi_center);
  assign pm = 19'(nb.east) + 19'(nb.phi_center) + 19'(nb.south) + 19'(nb.south_east);
  assign mp = 19'(nb.north_west) + 19'(nb.north) + 19'(nb.west) + 19'(nb.phi_center);
  assign mm = 19'(nb.south_west) + 19'(nb.south) + 19'(nb.west) + 19'(nb.phi_center);
  assign inv_s = $signed({1'b0, inv_spacing});

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r  <= pp - pm;
      dl_r  <= mp - mm;
      dt_r  <= pp - mp;
      db_r  <= pm - mm;
      nr_r  <= 17'(nb.east) - 17'(nb.phi_center);
      nl_r  <= 17'(nb.phi_center) - 17'(nb.west);
      nt_r  <= 17'(nb.north) - 17'(nb.phi_center);
      nb_r  <= 17'(nb.phi_center) - 17'(nb.south);
      pr_r  <= 44'(dr_r) * 44'(inv_s);
      pl_r  <= 44'(dl_r) * 44'(inv_s);
      pt_r  <= 44'(dt_r) * 44'(inv_s);
      pb_r  <= 44'(db_r) * 44'(inv_s);
      nr2_r <= GRAD_W'(nr_r);
      nl2_r <= GRAD_W'(nl_r);
      nt2_r <= GRAD_W'(nt_r);
      nb2_r <= GRAD_W'(nb_r);
    end
  end

  // The product is signed, so dropping the low 16 bits is a floor.
  assign right_n  = nr2_r;
  assign right_t  = pr_r[42:16];
  assign left_n   = nl2_r;
  assign left_t   = pl_r[42:16];
  assign top_n    = nt2_r;
  assign top_t    = pt_r[42:16];
  assign bottom_n = nb2_r;
  assign bottom_t = pb_r[42:16];

endmodule

// ===== sv/apff_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_div
// Pipelined restoring divider: floor(num * 2^16 / den) for num <= den.
// One compare-subtract per stage, 17 stages.
// ----------------------------------------------------------------------------
module apff_div
  import apff_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DIV_W-1:0] rem_r [QUO_W];
  logic [DIV_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      if (num >= den) begin
        rem_r[0] <= num - den;
        quo_r[0] <= QUO_W'(1);
      end else begin
        rem_r[0] <= num;
        quo_r[0] <= '0;
      end
    end
  end

  for (genvar i = 1; i < QUO_W; i++) begin : g_step
    logic [DIV_W:0] shifted;
    assign shifted = {rem_r[i-1], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_r[i-1];
        if (shifted >= {1'b0, den_r[i-1]}) begin
          rem_r[i] <= DIV_W'(shifted - {1'b0, den_r[i-1]});
          quo_r[i] <= {quo_r[i-1][QUO_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= DIV_W'(shifted);
          quo_r[i] <= {quo_r[i-1][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== sv/apff_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_edge
// Flux through one cell edge from its normal and tangential gradient:
// gradient test, anisotropy ratios, coefficients and saturated flux.
// ----------------------------------------------------------------------------
module apff_edge
  import apff_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [GRAD_W-1:0] nrm_in,
  input  logic signed [GRAD_W-1:0] tng_in,
  input  logic [COEF_W-1:0]        base_coef,
  input  logic [COEF_W-1:0]        aniso,
  input  logic [COEF_W-1:0]        deriv_gain,
  input  logic [31:0]              flat_thresh,
  output logic signed [FLUX_W-1:0] flux,
  output logic                     sat
);

  localparam int DLY = QUO_W;

  // gradient and magnitudes
  logic signed [GRAD_W-1:0] n1_r, t1_r, n2_r, t2_r, n3_r, t3_r, n4_r, t4_r, n5_r, t5_r;
  logic signed [GRAD_W-1:0] n6_r, t6_r;
  logic [GRAD_W-1:0] an1_r, at1_r, an2_r, at2_r;
  logic [53:0] sqn2_r, sqt2_r;
  logic [3:0]  k2_r;
  logic [54:0] m3_r;
  logic [14:0] bn3_r, bt3_r;
  logic [40:0] q3;
  logic [31:0] g4_r;
  logic        mz4_r, neg4_r;
  logic [29:0] u4_r, v4_r, bb4_r, bb5_r, diff5_r;
  logic        flat5_r, wneg5_r, flat6_r, wneg6_r;
  logic [30:0] s5_r;
  logic [59:0] uu5_r, vv5_r;
  logic [DIV_W-1:0] den6_r, numr6_r, numw6_r;

  // alignment across the dividers
  logic signed [GRAD_W-1:0] dn_r [DLY];
  logic signed [GRAD_W-1:0] dt_r [DLY];
  logic                     dflat_r [DLY];
  logic                     dwneg_r [DLY];
  logic [QUO_W-1:0]         ratio_r, ratio_w;

  // coefficients and flux
  logic [34:0] pe1_r, pm1_r;
  logic        flat1_r, wneg1_r, flat2_r, wneg2_r;
  logic signed [GRAD_W-1:0] n1f_r, t1f_r, n2f_r, t2f_r, n3f_r, t3f_r;
  logic [19:0] fct2;
  logic [37:0] pa2_r;
  logic [18:0] mag2_r;
  logic [21:0] a3_r, a4_r, a5_r;
  logic signed [19:0] ap3_r;
  logic signed [49:0] pa4_r;
  logic signed [46:0] pb4_r;
  logic signed [50:0] inner5;
  logic signed [42:0] t5f_r;
  logic [42:0] pl6_r;
  logic signed [44:0] ph6_r;
  logic signed [65:0] prod7;
  logic signed [51:0] fl7;
  logic        ovf7;
  logic signed [FLUX_W-1:0] flux_r;
  logic        sat_r;

  assign q3 = m3_r[54:14];

  always_ff @(posedge clk) begin
    if (en) begin
      // E1: magnitudes
      n1_r  <= nrm_in;
      t1_r  <= tng_in;
      an1_r <= nrm_in[GRAD_W-1] ? GRAD_W'(-nrm_in) : GRAD_W'(nrm_in);
      at1_r <= tng_in[GRAD_W-1] ? GRAD_W'(-tng_in) : GRAD_W'(tng_in);
      // E2: squares and normalizing shift
      n2_r   <= n1_r;
      t2_r   <= t1_r;
      an2_r  <= an1_r;
      at2_r  <= at1_r;
      sqn2_r <= 54'(an1_r) * 54'(an1_r);
      sqt2_r <= 54'(at1_r) * 54'(at1_r);
      k2_r   <= norm_shift((an1_r > at1_r) ? an1_r : at1_r);
      // E3
      n3_r  <= n2_r;
      t3_r  <= t2_r;
      m3_r  <= 55'(sqn2_r) + 55'(sqt2_r);
      bn3_r <= 15'(an2_r >> k2_r);
      bt3_r <= 15'(at2_r >> k2_r);
      // E4: |grad|^4 saturates once the Q.14 square magnitude reaches 2^16
      n4_r   <= n3_r;
      t4_r   <= t3_r;
      g4_r   <= (|q3[40:16]) ? '1 : 32'(q3[15:0]) * 32'(q3[15:0]);
      mz4_r  <= (m3_r == '0);
      u4_r   <= 30'(bn3_r) * 30'(bn3_r);
      v4_r   <= 30'(bt3_r) * 30'(bt3_r);
      bb4_r  <= 30'(bn3_r) * 30'(bt3_r);
      neg4_r <= n3_r[GRAD_W-1] ^ t3_r[GRAD_W-1];
      // E5
      n5_r    <= n4_r;
      t5_r    <= t4_r;
      flat5_r <= mz4_r | (g4_r < flat_thresh);
      s5_r    <= 31'(u4_r) + 31'(v4_r);
      diff5_r <= (u4_r >= v4_r) ? u4_r - v4_r : v4_r - u4_r;
      wneg5_r <= neg4_r ^ (u4_r < v4_r);
      uu5_r   <= 60'(u4_r) * 60'(u4_r);
      vv5_r   <= 60'(v4_r) * 60'(v4_r);
      bb5_r   <= bb4_r;
      // E6: divider operands
      n6_r    <= n5_r;
      t6_r    <= t5_r;
      flat6_r <= flat5_r;
      wneg6_r <= wneg5_r;
      den6_r  <= DIV_W'(s5_r) * DIV_W'(s5_r);
      numr6_r <= DIV_W'(uu5_r) + DIV_W'(vv5_r);
      numw6_r <= DIV_W'(bb5_r) * DIV_W'(diff5_r);
      // delay line beside the dividers
      dn_r[0]    <= n6_r;
      dt_r[0]    <= t6_r;
      dflat_r[0] <= flat6_r;
      dwneg_r[0] <= wneg6_r;
      for (int i = 1; i < DLY; i++) begin
        dn_r[i]    <= dn_r[i-1];
        dt_r[i]    <= dt_r[i-1];
        dflat_r[i] <= dflat_r[i-1];
        dwneg_r[i] <= dwneg_r[i-1];
      end
      // F1
      pe1_r   <= 35'(aniso) * 35'(ratio_r);
      pm1_r   <= 35'(deriv_gain) * 35'(ratio_w);
      flat1_r <= dflat_r[DLY-1];
      wneg1_r <= dwneg_r[DLY-1];
      n1f_r   <= dn_r[DLY-1];
      t1f_r   <= dt_r[DLY-1];
      // F2
      pa2_r   <= 38'(base_coef) * 38'(fct2);
      mag2_r  <= pm1_r[34:16];
      flat2_r <= flat1_r;
      wneg2_r <= wneg1_r;
      n2f_r   <= n1f_r;
      t2f_r   <= t1f_r;
      // F3: flat edges fall back to the isotropic coefficient
      a3_r  <= flat2_r ? 22'(base_coef) : pa2_r[37:16];
      ap3_r <= flat2_r ? '0 : (wneg2_r ? 20'(mag2_r) : -20'(mag2_r));
      n3f_r <= n2f_r;
      t3f_r <= t2f_r;
      // F4
      pa4_r <= 50'($signed({1'b0, a3_r})) * 50'(n3f_r);
      pb4_r <= 47'(ap3_r) * 47'(t3f_r);
      a4_r  <= a3_r;
      // F5
      t5f_r <= inner5[50:8];
      a5_r  <= a4_r;
      // F6: split multiply of a by the 43-bit bracket
      pl6_r <= 43'(a5_r) * 43'(t5f_r[20:0]);
      ph6_r <= 45'($signed({1'b0, a5_r})) * 45'($signed(t5f_r[42:21]));
      // F7: clip to the flux range
      if (ovf7) begin
        flux_r <= fl7[51] ? {1'b1, {(FLUX_W-1){1'b0}}} : {1'b0, {(FLUX_W-1){1'b1}}};
      end else begin
        flux_r <= fl7[FLUX_W-1:0];
      end
      sat_r <= ovf7;
    end
  end

  assign fct2   = 20'h10000 + 20'(pe1_r[34:16]);
  assign inner5 = 51'(pa4_r) + 51'(pb4_r);
  assign prod7  = {ph6_r, 21'd0} + {23'd0, pl6_r};
  assign fl7    = prod7[65:14];
  assign ovf7   = !((&fl7[51:31]) || !(|fl7[51:31]));

  apff_div u_div_ratio (
    .clk (clk),
    .en  (en),
    .num (numr6_r),
    .den (den6_r),
    .quo (ratio_r)
  );

  apff_div u_div_deriv (
    .clk (clk),
    .en  (en),
    .num (numw6_r),
    .den (den6_r),
    .quo (ratio_w)
  );

  assign flux = flux_r;
  assign sat  = sat_r;

endmodule

// ===== sv/anisotropic_phase_field_flux.sv =====
`timescale 1ns / 1ps
// Throughput: one neighborhood per cycle while the skid entry is free;
// most of the depth comes from the two 17-stage compare-subtract dividers
// in each edge unit.
// An output register and a one-entry skid register catch the result in flight
// when out_ch stalls; input closes only while the skid entry is full. Reset
// (rst_n, synchronous, active low) empties the pipeline and loads the defaults.
// ----------------------------------------------------------------------------
// anisotropic_phase_field_flux
// Top level: configuration registers, valid pipeline, right, left, top and
// bottom edge units and the output register with skid entry.
// ----------------------------------------------------------------------------
module anisotropic_phase_field_flux
  import apff_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  apff_in_if.sink          in_ch,
  apff_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [COEF_W-1:0] base_r, aniso_r, gain_r;
  logic [INV_W-1:0]  inv_r;
  logic [31:0]       thresh_r;

  logic [PIPE_LAT-1:0] vld_r;
  logic                en;
  logic signed [GRAD_W-1:0] rn, rt, ln, lt, tn, tt, bn, bt;
  flux_t               res;
  flux_t               out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                sat_rr, sat_lf, sat_tp, sat_bt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_COEF_RST;
      aniso_r  <= ANISO_RST;
      gain_r   <= DERIV_GAIN_RST;
      inv_r    <= INV_SPACING_RST;
      thresh_r <= FLAT_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_COEF:   base_r   <= cfg_data[COEF_W-1:0];
        CFG_ANISO:       aniso_r  <= cfg_data[COEF_W-1:0];
        CFG_DERIV_GAIN:  gain_r   <= cfg_data[COEF_W-1:0];
        CFG_INV_SPACING: inv_r    <= cfg_data[INV_W-1:0];
        CFG_FLAT_THRESH: thresh_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves while the skid entry is free.
  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  apff_stencil u_stencil (
    .clk         (clk),
    .en          (en),
    .nb          (in_ch.data),
    .inv_spacing (inv_r),
    .right_n     (rn),
    .right_t     (rt),
    .left_n      (ln),
    .left_t      (lt),
    .top_n       (tn),
    .top_t       (tt),
    .bottom_n    (bn),
    .bottom_t    (bt)
  );

  // Top and bottom edges take y as the normal component.
  apff_edge u_edge_right (
    .clk (clk), .en (en), .nrm_in (rn), .tng_in (rt),
    .base_coef (base_r), .aniso (aniso_r), .deriv_gain (gain_r), .flat_thresh (thresh_r),
    .flux (res.flux_right), .sat (sat_rr)
  );

  apff_edge u_edge_left (
    .clk (clk), .en (en), .nrm_in (ln), .tng_in (lt),
    .base_coef (base_r), .aniso (aniso_r), .deriv_gain (gain_r), .flat_thresh (thresh_r),
    .flux (res.flux_left), .sat (sat_lf)
  );

  apff_edge u_edge_top (
    .clk (clk), .en (en), .nrm_in (tn), .tng_in (tt),
    .base_coef (base_r), .aniso (aniso_r), .deriv_gain (gain_r), .flat_thresh (thresh_r),
    .flux (res.flux_top), .sat (sat_tp)
  );

  apff_edge u_edge_bottom (
    .clk (clk), .en (en), .nrm_in (bn), .tng_in (bt),
    .base_coef (base_r), .aniso (aniso_r), .deriv_gain (gain_r), .flat_thresh (thresh_r),
    .flux (res.flux_bottom), .sat (sat_bt)
  );

  assign res.saturated = sat_rr | sat_lf | sat_tp | sat_bt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_ch.ready) begin
      skid_valid_r <= vld_r[PIPE_LAT-1];
    end else begin
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_r <= skid_r;
      end
    end else if (out_valid_r && !out_ch.ready) begin
      skid_r <= res;
    end else begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// ===== sv/apff_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apff_checker
// Port-level checks of the flux block, bound to the top level.
// ----------------------------------------------------------------------------
module apff_checker
  import apff_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input flux_t out_data
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  // Input only closes after a stalled result.
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input blocked without an output stall");

  // A saturated result carries at least one clipped flux.
  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.flux_right == 32'sh7fffffff || out_data.flux_right == 32'sh80000000 ||
      out_data.flux_left == 32'sh7fffffff || out_data.flux_left == 32'sh80000000 ||
      out_data.flux_top == 32'sh7fffffff || out_data.flux_top == 32'sh80000000 ||
      out_data.flux_bottom == 32'sh7fffffff || out_data.flux_bottom == 32'sh80000000)
    else $error("saturated flag without a clipped flux");

endmodule

bind anisotropic_phase_field_flux apff_checker u_apff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== bench/anisotropic_phase_field_flux_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anisotropic_phase_field_flux_tb
// Streams 3x3 phi neighborhoods into the edge flux block under random gaps
// and output stalls, predicts the four fluxes and the saturation flag in
// fixed point, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module anisotropic_phase_field_flux_tb;
  import apff_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  apff_in_if in_ch ();
  apff_out_if out_ch ();

  anisotropic_phase_field_flux dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam longint CYCLE_LIMIT = 400000;

  // Block settings as the predictor sees them.
  longint unsigned as_coef, eps_coef, a12_coef, inv_sp, thresh;

  stencil_t pending_cells[$];
  flux_t    expected_fluxes[$];
  int       errors = 0;
  longint   cycles = 0;
  int       in_gap, out_gap;
  bit       feed_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint unsigned frac16(longint unsigned num,
                                             longint unsigned den);
    longint unsigned q, rem;
    q = num / den;
    rem = num % den;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint scale_tan(longint d);
    return fshr(d * longint'(inv_sp), 16);
  endfunction

  function automatic logic [31:0] edge_value(longint x, longint y, bit nx,
                                             inout bit sat);
    longint unsigned ax, ay, m, q, g4, mx, bx, by, u, v, den, r, diff, w, f, mag;
    longint a, ap, inner, flux;
    int k;
    bit neg;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax * ax + ay * ay;
    q = m >> 14;
    g4 = (q >= 65536) ? 64'hFFFF_FFFF : q * q;
    if (m == 0 || g4 < thresh) begin
      a = as_coef;
      ap = 0;
    end else begin
      mx = ax > ay ? ax : ay;
      k = 0;
      while ((mx >> k) >= 32768) k++;
      bx = ax >> k;
      by = ay >> k;
      u = bx * bx;
      v = by * by;
      den = (u + v) * (u + v);
      r = frac16(u * u + v * v, den);
      f = 65536 + ((eps_coef * r) >> 16);
      a = (as_coef * f) >> 16;
      diff = u >= v ? u - v : v - u;
      w = frac16(bx * by * diff, den);
      mag = (a12_coef * w) >> 16;
      neg = ((x < 0) != (y < 0)) != (u < v);
      ap = neg ? longint'(mag) : -longint'(mag);
    end
    inner = nx ? a * x + ap * y : a * y - ap * x;
    flux = fshr(a * fshr(inner, 8), 14);
    if (flux > 64'sd2147483647) begin
      flux = 64'sd2147483647;
      sat = 1'b1;
    end else if (flux < -64'sd2147483648) begin
      flux = -64'sd2147483648;
      sat = 1'b1;
    end
    return flux[31:0];
  endfunction

  function automatic flux_t predict_fluxes(stencil_t s);
    longint nw, n, ne, wv, c, e, sw, so, se, pp, pm, mp, mm;
    flux_t res;
    bit sat;
    nw = s.north_west; n = s.north; ne = s.north_east;
    wv = s.west; c = s.phi_center; e = s.east;
    sw = s.south_west; so = s.south; se = s.south_east;
    pp = ne + n + e + c;
    pm = e + c + so + se;
    mp = nw + n + wv + c;
    mm = sw + so + wv + c;
    sat = 1'b0;
    res.flux_right  = edge_value(e - c, scale_tan(pp - pm), 1'b1, sat);
    res.flux_left   = edge_value(c - wv, scale_tan(mp - mm), 1'b1, sat);
    res.flux_top    = edge_value(scale_tan(pp - mp), n - c, 1'b0, sat);
    res.flux_bottom = edge_value(scale_tan(pm - mm), c - so, 1'b0, sat);
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: one request per accepted item, with a random gap before each.
  // The request on the bus stays at the head of the queue until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= $urandom_range(0, 4);
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_fluxes.push_back(predict_fluxes(pending_cells.pop_front()));
      end
      if (in_gap == 0 && feed_en && pending_cells.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_cells[0];
        in_gap <= $urandom_range(0, 4);
      end else begin
        in_ch.valid <= 1'b0;
        if (in_gap != 0) in_gap <= in_gap - 1;
      end
    end
  end

  // Monitor with random output stalls.
  always @(posedge clk) begin
    flux_t want;
    int gap_draw;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_fluxes.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_fluxes.pop_front();
          if (out_ch.data.flux_right !== want.flux_right)
            report_mismatch("flux_right", out_ch.data.flux_right, want.flux_right);
          if (out_ch.data.flux_left !== want.flux_left)
            report_mismatch("flux_left", out_ch.data.flux_left, want.flux_left);
          if (out_ch.data.flux_top !== want.flux_top)
            report_mismatch("flux_top", out_ch.data.flux_top, want.flux_top);
          if (out_ch.data.flux_bottom !== want.flux_bottom)
            report_mismatch("flux_bottom", out_ch.data.flux_bottom,
                            want.flux_bottom);
          if (out_ch.data.saturated !== want.saturated)
            report_mismatch("saturated", out_ch.data.saturated, want.saturated);
        end
        gap_draw = $urandom_range(0, 4);
        out_ch.ready <= (gap_draw == 0);
        out_gap <= (gap_draw > 0) ? gap_draw - 1 : 0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE_COEF:   as_coef = value & 32'h3FFFF;
      CFG_ANISO:       eps_coef = value & 32'h3FFFF;
      CFG_DERIV_GAIN:  a12_coef = value & 32'h3FFFF;
      CFG_INV_SPACING: inv_sp = value & 32'hFFFFFF;
      CFG_FLAT_THRESH: thresh = value;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_phi();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      3: return 16'(int'($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random cells, or a base field plus small perturbations for gentle slopes.
  function automatic stencil_t rand_cell();
    stencil_t s;
    logic [15:0] b;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 9; i++) s[i*16 +: 16] = rand_phi();
    end else begin
      b = 16'($urandom_range(0, 32767)) - 16'd16384;
      for (int i = 0; i < 9; i++)
        s[i*16 +: 16] = b + 16'(int'($urandom_range(0, 512)) - 256);
    end
    return s;
  endfunction

  task automatic run_phase(int count, bit directed);
    stencil_t s;
    if (directed) begin
      s = '0; pending_cells.push_back(s);
      s = {9{16'h7FFF}}; pending_cells.push_back(s);
      s = {9{16'h8000}}; pending_cells.push_back(s);
      s = '0; s.east = 16'h7FFF; s.west = 16'h8000; pending_cells.push_back(s);
      s = '0; s.north = 16'h8000; s.south = 16'h7FFF; pending_cells.push_back(s);
      s = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
           16'h7FFF, 16'h8000, 16'h7FFF};
      pending_cells.push_back(s);
      s = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
           16'h8000, 16'h7FFF, 16'h8000};
      pending_cells.push_back(s);
      s = '0; s.east = 16'd1; pending_cells.push_back(s);
      s = '0; s.east = 16'd100; s.north = 16'd100; pending_cells.push_back(s);
      s = '0; s.east = 16'hFFFF; s.north_east = 16'd3; pending_cells.push_back(s);
    end
    for (int i = 0; i < count; i++) pending_cells.push_back(rand_cell());
    feed_en = 1'b1;
    wait (pending_cells.size() == 0 && !in_ch.valid && expected_fluxes.size() == 0);
    feed_en = 1'b0;
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  initial begin
    feed_en = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE_COEF;
    cfg_data = '0;
    as_coef = BASE_COEF_RST;
    eps_coef = ANISO_RST;
    a12_coef = DERIV_GAIN_RST;
    inv_sp = INV_SPACING_RST;
    thresh = FLAT_THRESH_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(400, 1'b1);

    // Extremes of every register, including an out-of-range index.
    write_reg(CFG_BASE_COEF, 32'hFFFF_FFFF);
    write_reg(CFG_ANISO, 32'h3FFFF);
    write_reg(CFG_DERIV_GAIN, 32'h3FFFF);
    write_reg(CFG_INV_SPACING, 32'hFFFF_FFFF);
    write_reg(CFG_FLAT_THRESH, 32'd0);
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_data <= 32'h1234;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_phase(300, 1'b1);

    write_reg(CFG_BASE_COEF, 32'd0);
    write_reg(CFG_ANISO, 32'd0);
    write_reg(CFG_DERIV_GAIN, 32'd0);
    write_reg(CFG_INV_SPACING, 32'd0);
    write_reg(CFG_FLAT_THRESH, 32'hFFFF_FFFF);
    run_phase(150, 1'b1);

    write_reg(CFG_BASE_COEF, 32'($urandom_range(0, 262143)));
    write_reg(CFG_ANISO, 32'($urandom_range(0, 262143)));
    write_reg(CFG_DERIV_GAIN, 32'($urandom_range(0, 262143)));
    write_reg(CFG_INV_SPACING, 32'($urandom_range(0, 262144)));
    write_reg(CFG_FLAT_THRESH, 32'($urandom_range(0, 4096)));
    run_phase(350, 1'b0);

    write_reg(CFG_BASE_COEF, CFG_W'(BASE_COEF_RST));
    write_reg(CFG_ANISO, CFG_W'(ANISO_RST));
    write_reg(CFG_DERIV_GAIN, CFG_W'(DERIV_GAIN_RST));
    write_reg(CFG_INV_SPACING, CFG_W'(INV_SPACING_RST));
    write_reg(CFG_FLAT_THRESH, 32'd1);
    run_phase(300, 1'b0);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
